### design/psp_pkg.sv
// ============================================================================
// psp_pkg: shared types and constants for the pedometer step/pace block
// Field widths, function codes and configuration register indexes.
// ============================================================================
package psp_pkg;

    localparam int CFG_W     = 13;  // configuration register width
    localparam int CFG_IDX_W = 1;   // configuration register index width
    localparam int AXIS_W    = 13;  // raw signed axis width
    localparam int MAG_W     = 15;  // |axis| * 4
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SSUM_W    = SQ_W + 2;
    localparam int TOTAL_W   = 16;  // step total, wraps
    localparam int OUT_W     = 14;  // window and pace output width
    localparam int SLOT_W    = 8;   // per-slot step count
    localparam int IDLE_W    = 8;   // idle seconds

    localparam logic [SLOT_W-1:0] SLOT_MAX = '1;
    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    localparam logic [CFG_W-1:0] GRAVITY_RST = 13'd1024;
    localparam logic [CFG_W-1:0] THRESH_RST  = 13'd500;

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_TICK   = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY = 1'b0,
        CFG_THRESH  = 1'b1
    } t_cfg_reg;

endpackage

### design/psp_ram.sv
// ============================================================================
// psp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without i_re.
// ============================================================================
module psp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 60,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/pedometer_step_pace.sv
// ============================================================================
// pedometer_step_pace: accelerometer step counter with per-second pace slew
// Threshold test on squared magnitude, 60-slot step history in RAM.
// ============================================================================
// Usage:
//   Input channel (i_valid/o_ready) carries either an accelerometer sample
//   (i_func = sample, axes valid) or a one-second tick (i_func = tick).
//   Every input transaction yields exactly one result transaction on the
//   output channel (o_valid/i_ready) with the step event, movement flag,
//   step total, window step sum and smoothed pace.
//   Config channel (i_cfg_valid/o_cfg_ready, always ready) writes gravity
//   baseline (index 0) and step threshold (index 1); write only while idle.
// Timing:
//   Each input passes stage 1 and stage 2 before o_valid: stage 1 squares
//   the axes and reads the current (or next, for a tick) history slot
//   from the slot RAM; stage 2 tests the threshold, updates state, writes
//   the slot back to RAM and loads the output register. Throughput is one
//   item per cycle while i_ready is high; the RAM read-modify-write is the
//   loop that sets it, with the stage-2 write forwarded to a stage-1 read.
// Reset:
//   Synchronous, active low. Slot valid bits all clear on reset, so an
//   unwritten slot reads as zero; no clearing pass, block ready at once.
// Stall:
//   While the receiver holds i_ready low the result is held, one more item
//   may enter stage 1, then o_ready drops until the output drains.
// ============================================================================
module pedometer_step_pace #(
    parameter int WINDOW_SECONDS = 60
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input item channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_func,
    input  logic signed [psp_pkg::AXIS_W-1:0]  i_accel_x,
    input  logic signed [psp_pkg::AXIS_W-1:0]  i_accel_y,
    input  logic signed [psp_pkg::AXIS_W-1:0]  i_accel_z,
    // result channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_step_event,
    output logic                               o_moving,
    output logic [psp_pkg::TOTAL_W-1:0]        o_step_total,
    output logic [psp_pkg::OUT_W-1:0]          o_window_steps,
    output logic [psp_pkg::OUT_W-1:0]          o_pace,
    // configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [psp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [psp_pkg::CFG_W-1:0]          i_cfg_data
);

    import psp_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_SECONDS);
    localparam int SUM_W = $clog2(WINDOW_SECONDS * 255 + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SECONDS - 1);

    // |axis| * 4 of a two's complement sample; -4096 maps to 4096
    function automatic logic [MAG_W-1:0] scaled_abs(input logic signed [AXIS_W-1:0] a);
        logic [AXIS_W-1:0] mag;
        mag = a[AXIS_W-1] ? AXIS_W'(-a) : AXIS_W'(a);
        return {mag, 2'b00};
    endfunction

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_LAST) ? '0 : IDX_W'(idx + 1'b1);
    endfunction

    // ---------------------------------------------------------------- config
    logic [CFG_W-1:0]   r_gravity;
    logic [CFG_W-1:0]   r_thresh;
    logic [CFG_W:0]     w_hi;
    logic [CFG_W-1:0]   w_lo;
    logic [2*CFG_W+1:0] r_hi_sq;
    logic [2*CFG_W-1:0] r_lo_sq;
    logic               r_lo_en;

    assign o_cfg_ready = 1'b1;
    assign w_hi = {1'b0, r_gravity} + {1'b0, r_thresh};
    assign w_lo = r_gravity - r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RST;
            r_thresh  <= THRESH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_GRAVITY: r_gravity <= i_cfg_data;
                CFG_THRESH:  r_thresh  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // band bounds squared, refreshed every cycle from the config registers
    always_ff @(posedge i_clk) begin
        r_hi_sq <= w_hi * w_hi;
        r_lo_sq <= w_lo * w_lo;
        r_lo_en <= (r_gravity > r_thresh);
    end

    // ---------------------------------------------------------------- state
    logic                    r_s1_valid;
    logic                    r_s1_tick;
    logic [SQ_W-1:0]         r_sq_x, r_sq_y, r_sq_z;
    logic                    r_byp_hit;
    logic [SLOT_W-1:0]       r_byp_data;
    logic                    r_rd_vld;

    logic                    r_prev_above, n_prev_above;
    logic                    r_moving, n_moving;
    logic [TOTAL_W-1:0]      r_step_cnt, n_step_cnt;
    logic [IDX_W-1:0]        r_slot_idx, n_slot_idx;
    logic [SUM_W-1:0]        r_win_sum, n_win_sum;
    logic [SUM_W-1:0]        r_pace, n_pace;
    logic [IDLE_W-1:0]       r_idle, n_idle;
    logic                    r_slot_vld [WINDOW_SECONDS];

    logic                    r_o_valid;
    logic                    r_o_event, n_o_event;

    // ---------------------------------------------------------------- handshake
    logic w_accept;
    logic w_commit;

    assign w_commit = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready  = !r_s1_valid || w_commit;
    assign w_accept = i_valid && o_ready;

    // ---------------------------------------------------------------- slot RAM
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [SLOT_W-1:0]  w_wdata;
    logic [IDX_W-1:0]   w_raddr;
    logic [SLOT_W-1:0]  w_rdata;

    psp_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (WINDOW_SECONDS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------------------------------------------------------- stage 2
    logic [SLOT_W-1:0]  w_cur_count;
    logic [SSUM_W-1:0]  w_ssum;
    logic               w_above;
    logic [IDX_W-1:0]   w_idx_inc;
    logic [SUM_W-1:0]   w_ws_dec;

    // slot value: forwarded write, else RAM, else never written (zero)
    assign w_cur_count = r_byp_hit ? r_byp_data : (r_rd_vld ? w_rdata : '0);
    assign w_ssum  = SSUM_W'(r_sq_x) + SSUM_W'(r_sq_y) + SSUM_W'(r_sq_z);
    assign w_above = (w_ssum > SSUM_W'(r_hi_sq)) ||
                     (r_lo_en && (w_ssum < SSUM_W'(r_lo_sq)));
    assign w_idx_inc = idx_next(r_slot_idx);
    assign w_ws_dec  = r_win_sum - SUM_W'(w_cur_count);

    always_comb begin
        n_prev_above = r_prev_above;
        n_moving     = r_moving;
        n_step_cnt   = r_step_cnt;
        n_slot_idx   = r_slot_idx;
        n_win_sum    = r_win_sum;
        n_pace       = r_pace;
        n_idle       = r_idle;
        n_o_event    = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_slot_idx;
        w_wdata      = '0;
        if (w_commit) begin
            if (r_s1_tick) begin
                // idle count, then slot advance and clear, then pace
                if (r_moving) begin
                    n_idle = '0;
                end else if (r_idle != IDLE_MAX) begin
                    n_idle = r_idle + 1'b1;
                end
                n_slot_idx = w_idx_inc;
                n_win_sum  = w_ws_dec;
                w_we       = 1'b1;
                w_waddr    = w_idx_inc;
                w_wdata    = '0;
                if (r_moving) begin
                    if (r_pace < w_ws_dec) begin
                        n_pace = r_pace + 1'b1;
                    end else if (r_pace > w_ws_dec) begin
                        n_pace = r_pace - 1'b1;
                    end
                end else if ((n_idle != '0) && (r_pace != '0)) begin
                    n_pace = r_pace - 1'b1;
                end
            end else begin
                n_moving     = w_above;
                n_prev_above = w_above;
                if (w_above && !r_prev_above) begin
                    n_o_event  = 1'b1;
                    n_step_cnt = r_step_cnt + 1'b1;
                    // full slot: step still counts in the total
                    if (w_cur_count != SLOT_MAX) begin
                        w_we      = 1'b1;
                        w_waddr   = r_slot_idx;
                        w_wdata   = w_cur_count + 1'b1;
                        n_win_sum = r_win_sum + 1'b1;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 1
    // read address uses the slot index as left by the item committing now
    assign w_raddr = (t_func'(i_func) == FUNC_TICK) ? idx_next(n_slot_idx) : n_slot_idx;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_tick  <= (t_func'(i_func) == FUNC_TICK);
            r_sq_x     <= scaled_abs(i_accel_x) * scaled_abs(i_accel_x);
            r_sq_y     <= scaled_abs(i_accel_y) * scaled_abs(i_accel_y);
            r_sq_z     <= scaled_abs(i_accel_z) * scaled_abs(i_accel_z);
            r_byp_hit  <= w_we && (w_waddr == w_raddr);
            r_byp_data <= w_wdata;
            r_rd_vld   <= r_slot_vld[w_raddr];
        end
    end

    // ---------------------------------------------------------------- control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
            r_prev_above <= 1'b0;
            r_moving     <= 1'b0;
            r_step_cnt   <= '0;
            r_slot_idx   <= '0;
            r_win_sum    <= '0;
            r_pace       <= '0;
            r_idle       <= '0;
            for (int i = 0; i < WINDOW_SECONDS; i++) begin
                r_slot_vld[i] <= 1'b0;
            end
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_commit) begin
                r_s1_valid <= 1'b0;
            end
            if (w_commit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            r_prev_above <= n_prev_above;
            r_moving     <= n_moving;
            r_step_cnt   <= n_step_cnt;
            r_slot_idx   <= n_slot_idx;
            r_win_sum    <= n_win_sum;
            r_pace       <= n_pace;
            r_idle       <= n_idle;
            if (w_we) begin
                r_slot_vld[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_o_event <= n_o_event;
        end
    end

    // ---------------------------------------------------------------- outputs
    // state registers only move on commit, so they stay put while stalled
    assign o_valid        = r_o_valid;
    assign o_step_event   = r_o_event;
    assign o_moving       = r_moving;
    assign o_step_total   = r_step_cnt;
    assign o_window_steps = OUT_W'(r_win_sum);
    assign o_pace         = OUT_W'(r_pace);

endmodule

### design/psp_chk.sv
// ============================================================================
// psp_chk: port-level checker for the pedometer step/pace block
// Watches the result channel; bound to the top level.
// ============================================================================
module psp_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_step_event,
    input logic                        o_moving,
    input logic [psp_pkg::TOTAL_W-1:0] o_step_total,
    input logic [psp_pkg::OUT_W-1:0]   o_window_steps,
    input logic [psp_pkg::OUT_W-1:0]   o_pace
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a new step only comes from a sample outside the band
    a_event_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_step_event |-> o_moving)
        else $error("step event without movement");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_step_event) && $stable(o_moving) &&
            $stable(o_step_total) && $stable(o_window_steps) && $stable(o_pace))
        else $error("result changed while stalled");

endmodule

bind pedometer_step_pace psp_chk u_psp_chk (.*);
